// ===== rtl/core/differential_drive_odometry_assert.svh =====
// Assertion macros shared by the odometry RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// Consequence must hold in the cycle after the antecedent
`define DDO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("odometry assertion failed");

// Consequence must hold in the same cycle as the antecedent
`define DDO_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("odometry assertion failed");

`endif

// ===== rtl/core/ddo_pkg.sv =====
// Shared types, widths and constants of the odometry block.
// No dependencies; imported by the controller, datapath and top level.
package ddo_pkg;

	localparam int COUNTER_BITS_DEF = 16;
	localparam int CORDIC_STEPS_DEF = 20;

	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;
	localparam int POS_W     = 48;
	localparam int HEAD_W    = 25;
	localparam int SPD_W     = 27;
	localparam int RATE_W    = 40;
	localparam int ACC_W     = 48;
	localparam int W_W       = 36;   // internal angular speed, never exceeds this
	localparam int WRAP_W    = 29;
	localparam int CORD_W    = 48;
	localparam int Z_W       = 34;
	localparam int CNT_W     = 6;

	localparam logic signed [WRAP_W-1:0] HALF_TURN = 29'sd11796480;
	localparam logic signed [WRAP_W-1:0] FULL_TURN = 29'sd23592960;
	localparam logic [29:0]              CORDIC_K  = 30'd652032874;
	localparam logic signed [Z_W-1:0]    Q24_90    = 34'sd1509949440;
	localparam logic signed [Z_W-1:0]    Q24_180   = 34'sd3019898880;
	// ceil(2^35 / 125): exact quotient by 125 for any 32-bit dividend
	localparam logic [28:0]              RECIP_125 = 29'd274877907;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEFT_SCALE  = 2'd0,
		CFG_RIGHT_SCALE = 2'd1,
		CFG_TURN_GAIN   = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_IDLE  = 4'd0,
		OP_LOAD  = 4'd1,
		OP_SPEED = 4'd2,
		OP_TURN  = 4'd3,
		OP_RATE  = 4'd4,
		OP_DIV   = 4'd5,
		OP_MID   = 4'd6,
		OP_WRAP  = 4'd7,
		OP_CINIT = 4'd8,
		OP_ROT   = 4'd9,
		OP_POS   = 4'd10,
		OP_FIN   = 4'd11,
		OP_PUB   = 4'd12
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [CNT_W-1:0] cnt;
	} dp_cmd_t;

	typedef struct packed {
		logic wrap_ok;
	} dp_status_t;

	// Clamp to the wheel speed range
	function automatic logic signed [SPD_W-1:0] sat_speed(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd67108863;
		lo = -64'sd67108864;
		if (v > hi) begin
			sat_speed = hi[SPD_W-1:0];
		end else if (v < lo) begin
			sat_speed = lo[SPD_W-1:0];
		end else begin
			sat_speed = v[SPD_W-1:0];
		end
	endfunction

	// Arctangent of 2^-i in Q.24 degrees
	function automatic logic [29:0] atan_q24(input logic [4:0] i);
		case (i)
			5'd0:    atan_q24 = 30'd754974720;
			5'd1:    atan_q24 = 30'd445687602;
			5'd2:    atan_q24 = 30'd235489088;
			5'd3:    atan_q24 = 30'd119537938;
			5'd4:    atan_q24 = 30'd60000934;
			5'd5:    atan_q24 = 30'd30029717;
			5'd6:    atan_q24 = 30'd15018523;
			5'd7:    atan_q24 = 30'd7509720;
			5'd8:    atan_q24 = 30'd3754917;
			5'd9:    atan_q24 = 30'd1877466;
			5'd10:   atan_q24 = 30'd938734;
			5'd11:   atan_q24 = 30'd469367;
			5'd12:   atan_q24 = 30'd234684;
			5'd13:   atan_q24 = 30'd117342;
			5'd14:   atan_q24 = 30'd58671;
			5'd15:   atan_q24 = 30'd29335;
			5'd16:   atan_q24 = 30'd14668;
			5'd17:   atan_q24 = 30'd7334;
			5'd18:   atan_q24 = 30'd3667;
			5'd19:   atan_q24 = 30'd1833;
			5'd20:   atan_q24 = 30'd917;
			5'd21:   atan_q24 = 30'd458;
			5'd22:   atan_q24 = 30'd229;
			5'd23:   atan_q24 = 30'd115;
			5'd24:   atan_q24 = 30'd57;
			5'd25:   atan_q24 = 30'd29;
			5'd26:   atan_q24 = 30'd14;
			5'd27:   atan_q24 = 30'd7;
			5'd28:   atan_q24 = 30'd4;
			5'd29:   atan_q24 = 30'd2;
			5'd30:   atan_q24 = 30'd1;
			default: atan_q24 = 30'd0;
		endcase
	endfunction

endpackage

// ===== rtl/core/ddo_ctrl.sv =====
// Sequencing controller of the odometry block: handshakes and datapath commands.
// Depends on ddo_pkg and differential_drive_odometry_assert.svh.
`include "differential_drive_odometry_assert.svh"
module ddo_ctrl #(
	parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output ddo_pkg::dp_cmd_t    cmd,
	input  ddo_pkg::dp_status_t status
);
	import ddo_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_SPEED = 13'b0000000000010,
		ST_TURN  = 13'b0000000000100,
		ST_RATE  = 13'b0000000001000,
		ST_DIV   = 13'b0000000010000,
		ST_MID   = 13'b0000000100000,
		ST_WRAPM = 13'b0000001000000,
		ST_CINIT = 13'b0000010000000,
		ST_ROT   = 13'b0000100000000,
		ST_POS   = 13'b0001000000000,
		ST_WRAPP = 13'b0010000000000,
		ST_FIN   = 13'b0100000000000,
		ST_OUT   = 13'b1000000000000
	} state_t;

	localparam logic [CNT_W-1:0] ROT_LAST = CNT_W'(CORDIC_STEPS - 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;
	logic             in_acc;
	logic             slot_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Advance the sequence and issue one datapath command a cycle
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q && out_stall;
		cmd.op      = OP_IDLE;
		cmd.cnt     = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cmd.op  = OP_LOAD;
					state_d = ST_SPEED;
				end
			end
			ST_SPEED: begin
				cmd.op  = OP_SPEED;
				state_d = ST_TURN;
			end
			ST_TURN: begin
				cmd.op  = OP_TURN;
				state_d = ST_RATE;
			end
			ST_RATE: begin
				cmd.op  = OP_RATE;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op  = OP_DIV;
				state_d = ST_MID;
			end
			ST_MID: begin
				cmd.op  = OP_MID;
				state_d = ST_WRAPM;
			end
			ST_WRAPM: begin
				cmd.op = OP_WRAP;
				if (status.wrap_ok) begin
					state_d = ST_CINIT;
				end
			end
			ST_CINIT: begin
				cmd.op  = OP_CINIT;
				cnt_d   = '0;
				state_d = ST_ROT;
			end
			ST_ROT: begin
				cmd.op = OP_ROT;
				if (cnt_q == ROT_LAST) begin
					state_d = ST_POS;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_POS: begin
				cmd.op  = OP_POS;
				state_d = ST_WRAPP;
			end
			ST_WRAPP: begin
				cmd.op = OP_WRAP;
				if (status.wrap_ok) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.op  = OP_FIN;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (slot_free) begin
					cmd.op      = OP_PUB;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold state, counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	`DDO_ASSERT_NEXT(a_accept_starts, in_acc, state_q == ST_SPEED)
	`DDO_ASSERT_NOW(a_rot_in_range, state_q == ST_ROT, cnt_q <= ROT_LAST)
	`DDO_ASSERT_NEXT(a_publish, (state_q == ST_OUT) && slot_free, out_valid && state_q == ST_IDLE)

endmodule

// ===== rtl/core/ddo_datapath.sv =====
// Odometry datapath: configuration, wheel speeds, divider, CORDIC and pose registers.
// Depends on ddo_pkg; driven by ddo_ctrl commands.
module ddo_datapath #(
	parameter int COUNTER_BITS = ddo_pkg::COUNTER_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ddo_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ddo_pkg::CFG_W-1:0]             cfg_data,
	input  logic [COUNTER_BITS-1:0]               left_count,
	input  logic [COUNTER_BITS-1:0]               right_count,
	input  ddo_pkg::dp_cmd_t                      cmd,
	output ddo_pkg::dp_status_t                   status,
	output logic signed [ddo_pkg::POS_W-1:0]      pos_x,
	output logic signed [ddo_pkg::POS_W-1:0]      pos_y,
	output logic signed [ddo_pkg::HEAD_W-1:0]     heading,
	output logic signed [ddo_pkg::SPD_W-1:0]      lin_speed,
	output logic signed [ddo_pkg::RATE_W-1:0]     ang_speed,
	output logic signed [ddo_pkg::ACC_W-1:0]      lin_accel,
	output logic signed [ddo_pkg::ACC_W-1:0]      ang_accel
);
	import ddo_pkg::*;

	localparam int PW = COUNTER_BITS + CFG_W + 1;

	logic [CFG_W-1:0]          left_scale_q, right_scale_q, turn_gain_q;
	logic [COUNTER_BITS-1:0]   last_l_q, last_r_q;
	logic [COUNTER_BITS-1:0]   dl, dr;
	logic signed [PW-1:0]      prod_l_s1, prod_r_s1;
	logic signed [SPD_W-1:0]   sl, sr;
	logic signed [SPD_W:0]     ssum;
	logic signed [SPD_W-1:0]   v_q, prev_v_q;
	logic signed [SPD_W:0]     diff_q;
	logic signed [52:0]        wprod_q;
	logic signed [52:0]        wround;
	logic signed [W_W-1:0]     w_new, w_q, prev_w_q;
	logic [W_W-1:0]            w_mag;
	logic signed [57:0]        kx_q;
	logic [60:0]               recip_p;
	logic [25:0]               quo_q;
	logic signed [WRAP_W-1:0]  q1000, q2000;
	logic signed [WRAP_W-1:0]  wrap_q;
	logic signed [WRAP_W-1:0]  phi_ext;
	logic signed [HEAD_W-1:0]  phi_q, mid;
	logic signed [Z_W-1:0]     z0, z_q;
	logic                      flip_q;
	logic signed [CORD_W-1:0]  cx_q, cy_q, xs, ys, rx, ry;
	logic signed [Z_W-1:0]     atan_z;
	logic signed [POS_W-1:0]   x_acc_q, y_acc_q;
	logic signed [ACC_W-1:0]   la_q, aa_q;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_scale_q  <= 24'd463244;
			right_scale_q <= 24'd463244;
			turn_gain_q   <= 24'd11011543;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEFT_SCALE:  left_scale_q  <= cfg_data;
				CFG_RIGHT_SCALE: right_scale_q <= cfg_data;
				CFG_TURN_GAIN:   turn_gain_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Wrapped count deltas and wheel speed rounding
	assign dl    = left_count - last_l_q;
	assign dr    = right_count - last_r_q;
	assign sl    = sat_speed((64'(prod_l_s1) + 64'sd128) >>> 8);
	assign sr    = sat_speed((64'(prod_r_s1) + 64'sd128) >>> 8);
	assign ssum  = (SPD_W+1)'(sr) + (SPD_W+1)'(sl);

	// Angular speed, rounded to Q.16
	assign wround = wprod_q + 53'sd32768;
	assign w_new  = wround[51:16];
	assign w_mag  = w_new[W_W-1] ? W_W'(-w_new) : W_W'(w_new);

	// Divide the magnitude by 1000: drop the factor eight, multiply by the reciprocal of 125
	assign recip_p = w_mag[34:3] * RECIP_125;

	// Signed quotients, truncated toward zero
	assign q1000   = w_q[W_W-1] ? -$signed({3'b000, quo_q[25:0]}) : $signed({3'b000, quo_q[25:0]});
	assign q2000   = w_q[W_W-1] ? -$signed({4'b0000, quo_q[25:1]}) : $signed({4'b0000, quo_q[25:1]});
	assign phi_ext = WRAP_W'(phi_q);

	// Heading wrap status
	assign status.wrap_ok = !wrap_q[WRAP_W-1] && (wrap_q < FULL_TURN);

	// CORDIC operands
	assign mid    = HEAD_W'(wrap_q - HALF_TURN);
	assign z0     = {mid[HEAD_W-1], mid, 8'd0};
	assign xs     = cx_q >>> cmd.cnt;
	assign ys     = cy_q >>> cmd.cnt;
	assign atan_z = $signed({4'b0000, atan_q24(cmd.cnt[4:0])});
	assign rx     = (cx_q + 48'sd32768) >>> 16;
	assign ry     = (cy_q + 48'sd32768) >>> 16;

	// Control-state registers: previous counts, pose and previous speeds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_l_q <= '0;
			last_r_q <= '0;
			x_acc_q  <= '0;
			y_acc_q  <= '0;
			phi_q    <= '0;
			prev_v_q <= '0;
			prev_w_q <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					last_l_q <= left_count;
					last_r_q <= right_count;
				end
				OP_POS: begin
					x_acc_q  <= x_acc_q + (flip_q ? -rx : rx);
					y_acc_q  <= y_acc_q + (flip_q ? -ry : ry);
					prev_v_q <= v_q;
					prev_w_q <= w_q;
				end
				OP_FIN: begin
					phi_q <= HEAD_W'(wrap_q - HALF_TURN);
				end
				default: ;
			endcase
		end
	end

	// Working registers of one word
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				prod_l_s1 <= $signed(dl) * $signed({1'b0, left_scale_q});
				prod_r_s1 <= $signed(dr) * $signed({1'b0, right_scale_q});
			end
			OP_SPEED: begin
				v_q    <= SPD_W'(ssum >>> 1);
				diff_q <= (SPD_W+1)'(sr) - (SPD_W+1)'(sl);
			end
			OP_TURN: begin
				wprod_q <= diff_q * $signed({1'b0, turn_gain_q});
			end
			OP_RATE: begin
				w_q   <= w_new;
				kx_q  <= v_q * $signed({1'b0, CORDIC_K});
				la_q  <= (ACC_W'(v_q) - ACC_W'(prev_v_q)) * ACC_W'(11'sd1000);
			end
			OP_DIV: begin
				quo_q <= recip_p[60:35];
			end
			OP_MID: begin
				wrap_q <= phi_ext + q2000 + HALF_TURN;
				aa_q   <= (ACC_W'(w_q) - ACC_W'(prev_w_q)) * ACC_W'(11'sd1000);
			end
			OP_WRAP: begin
				if (wrap_q[WRAP_W-1]) begin
					wrap_q <= wrap_q + FULL_TURN;
				end else if (wrap_q >= FULL_TURN) begin
					wrap_q <= wrap_q - FULL_TURN;
				end
			end
			OP_CINIT: begin
				cx_q <= {{4{kx_q[57]}}, kx_q[57:14]};
				cy_q <= '0;
				if (z0 > Q24_90) begin
					z_q    <= z0 - Q24_180;
					flip_q <= 1'b1;
				end else if (z0 < -Q24_90) begin
					z_q    <= z0 + Q24_180;
					flip_q <= 1'b1;
				end else begin
					z_q    <= z0;
					flip_q <= 1'b0;
				end
			end
			OP_ROT: begin
				if (!z_q[Z_W-1]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					z_q  <= z_q - atan_z;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					z_q  <= z_q + atan_z;
				end
			end
			OP_POS: begin
				wrap_q <= phi_ext + q1000 + HALF_TURN;
			end
			OP_PUB: begin
				pos_x     <= x_acc_q;
				pos_y     <= y_acc_q;
				heading   <= phi_q;
				lin_speed <= v_q;
				ang_speed <= RATE_W'(w_q);
				lin_accel <= la_q;
				ang_accel <= aa_q;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/differential_drive_odometry.sv =====
// Top level of the differential-drive odometry block.
// Depends on ddo_pkg, ddo_ctrl and ddo_datapath.
//
//   channel  direction  handshake           word
//   in       input      in_valid/in_stall   left_count, right_count
//   out      output     out_valid/out_stall pose, speeds, speed changes
//   cfg      input      cfg_we              cfg_index, cfg_data
//
// From acceptance to result the time is set by CORDIC_STEPS rotations, a reciprocal
// divide by 1000 and at most one wrap step for the midpoint and two for the heading.
// The next word can be taken in the cycle after the result is published.
// Reset clears the pose, previous counts and speeds and restores the register defaults.
// A new word is taken while the last result still waits under out_stall.
module differential_drive_odometry #(
	parameter int COUNTER_BITS = ddo_pkg::COUNTER_BITS_DEF,
	parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ddo_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ddo_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [COUNTER_BITS-1:0]           left_count,
	input  logic [COUNTER_BITS-1:0]           right_count,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [ddo_pkg::POS_W-1:0]  pos_x,
	output logic signed [ddo_pkg::POS_W-1:0]  pos_y,
	output logic signed [ddo_pkg::HEAD_W-1:0] heading,
	output logic signed [ddo_pkg::SPD_W-1:0]  lin_speed,
	output logic signed [ddo_pkg::RATE_W-1:0] ang_speed,
	output logic signed [ddo_pkg::ACC_W-1:0]  lin_accel,
	output logic signed [ddo_pkg::ACC_W-1:0]  ang_accel
);
	import ddo_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequence the word through the datapath
	ddo_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.status   (status)
	);

	// Compute speeds and advance the pose
	ddo_datapath #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.left_count (left_count),
		.right_count(right_count),
		.cmd        (cmd),
		.status     (status),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.heading    (heading),
		.lin_speed  (lin_speed),
		.ang_speed  (ang_speed),
		.lin_accel  (lin_accel),
		.ang_accel  (ang_accel)
	);

endmodule
